[hdl/rc4x_pkg.sv]
// Shared types and constants for the RC4 stream cipher with output mask.
// No dependencies; every other file in this folder imports this package.
package rc4x_pkg;

    localparam int BYTE_W        = 8;
    localparam int PERM_DEPTH    = 256;
    localparam int KEY_DEPTH_DEF = 32;

    localparam logic [BYTE_W-1:0] OUT_MASK  = 8'd42;
    localparam logic [BYTE_W-1:0] LAST_STEP = 8'hFF;

    localparam logic ACT_KEY  = 1'b0;
    localparam logic ACT_DATA = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PG_RDY,
        ST_PG_RDT,
        ST_PG_FIN,
        ST_KS_RDI,
        ST_KS_RDJ,
        ST_KS_WRI,
        ST_KS_WRJ
    } state_t;

    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } perm_wr_t;

endpackage

[hdl/rc4x_perm_ram.sv]
// Permutation memory: 256 bytes, one registered read port, one write port.
// An entry never written since the last clear reads as its own index. Uses rc4x_pkg.
module rc4x_perm_ram
    import rc4x_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              rd_en,
    input  logic [BYTE_W-1:0] rd_addr,
    input  perm_wr_t          wr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0]     mem [PERM_DEPTH];
    logic [PERM_DEPTH-1:0] valid_reg;
    logic [BYTE_W-1:0]     mem_q_reg;
    logic [BYTE_W-1:0]     addr_q_reg;
    logic                  hit_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            mem_q_reg  <= mem[rd_addr];
            addr_q_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_q_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_q_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Entries not written since the last clear hold the identity.
    assign rd_data = hit_q_reg ? mem_q_reg : addr_q_reg;

endmodule

[hdl/rc4x_key_ram.sv]
// Key byte store: simple synchronous RAM with a registered read port.
// Contents are undefined until written. Uses rc4x_pkg for the byte width.
module rc4x_key_ram
    import rc4x_pkg::*;
#(
    parameter int DEPTH = KEY_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/rc4_xor42_stream_cipher.sv]
// Top level of the RC4 stream cipher with an XOR-42 output mask.
// Depends on rc4x_pkg, rc4x_perm_ram and rc4x_key_ram.
//
//   Channel  Handshake             Payload                        Direction
//   -------  --------------------  -----------------------------  ---------
//   input    in_valid / in_stall   action, byte_value, last_key   into block
//   output   out_valid / out_stall out_byte                       out of block
//
// A key byte that is not the last leaves the block idle. A data byte steps
// through ST_PG_RDY, ST_PG_RDT and ST_PG_FIN: the single permutation port
// serves the reads of S[x], S[y] and S[S[x]+S[y]] one after another, and the
// swap writes go out in ST_PG_RDT and ST_PG_FIN. A last key byte starts 256
// key schedule steps (ST_KS_RDI to ST_KS_WRJ), during which in_stall stays high.
// Reset takes effect at once: the permutation's valid bits clear, so it reads
// as the identity without any clearing pass. A result waits in the output
// register while out_stall is high; the next item is still taken meanwhile,
// but a data byte holds in its last cycle until the output register is free.
module rc4_xor42_stream_cipher
    import rc4x_pkg::*;
#(
    parameter int KEY_DEPTH = KEY_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic              last_key,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] out_byte
);

    localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int CW = $clog2(KEY_DEPTH + 1);

    state_t state_reg, state_next;

    // RC4 indices, key-schedule counters and working registers.
    logic [BYTE_W-1:0] x_reg, x_next;
    logic [BYTE_W-1:0] y_reg, y_next;
    logic [BYTE_W-1:0] i_reg, i_next;
    logic [BYTE_W-1:0] j_reg, j_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [BYTE_W-1:0] a_reg, a_next;
    logic [BYTE_W-1:0] b_reg, b_next;
    logic [BYTE_W-1:0] t_reg, t_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;

    // Memory controls.
    logic              perm_clear;
    logic              perm_rd_en;
    logic [BYTE_W-1:0] perm_rd_addr;
    perm_wr_t          perm_wr;
    logic [BYTE_W-1:0] perm_rd_data;
    logic              key_wr_en;
    logic              key_rd_en;
    logic [BYTE_W-1:0] key_rd_data;

    logic              in_xfer;
    logic              out_free;
    logic [CW-1:0]     k_inc;
    logic [BYTE_W-1:0] ks;

    // New input is taken only while idle.
    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign k_inc    = CW'(k_reg) + CW'(1);

    // The swap has written S[x] = b and will write S[y] = a; the read of
    // S[a+b] was issued before those writes landed, so matching entries are
    // taken from the registers, with S[y] winning when x equals y.
    always_comb
    begin
        if (t_reg == y_reg)
        begin
            ks = a_reg;
        end
        else if (t_reg == x_reg)
        begin
            ks = b_reg;
        end
        else
        begin
            ks = perm_rd_data;
        end
    end

    rc4x_perm_ram u_perm (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (perm_clear),
        .rd_en   (perm_rd_en),
        .rd_addr (perm_rd_addr),
        .wr      (perm_wr),
        .rd_data (perm_rd_data)
    );

    rc4x_key_ram #(
        .DEPTH (KEY_DEPTH),
        .AW    (KW)
    ) u_key (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (count_reg[KW-1:0]),
        .wr_data (byte_value),
        .rd_en   (key_rd_en),
        .rd_addr (k_reg),
        .rd_data (key_rd_data)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (action == ACT_DATA)
                    begin
                        state_next = ST_PG_RDY;
                    end
                    else if (last_key)
                    begin
                        state_next = ST_KS_RDI;
                    end
                end
            end
            ST_PG_RDY: state_next = ST_PG_RDT;
            ST_PG_RDT: state_next = ST_PG_FIN;
            ST_PG_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_KS_RDI: state_next = ST_KS_RDJ;
            ST_KS_RDJ: state_next = ST_KS_WRI;
            ST_KS_WRI: state_next = ST_KS_WRJ;
            ST_KS_WRJ:
            begin
                if (i_reg == LAST_STEP)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_KS_RDI;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        x_next         = x_reg;
        y_next         = y_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        t_next         = t_reg;
        data_next      = data_reg;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg && out_stall;
        perm_clear     = 1'b0;
        perm_rd_en     = 1'b0;
        perm_rd_addr   = x_reg;
        perm_wr        = '0;
        key_wr_en      = 1'b0;
        key_rd_en      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (action == ACT_DATA)
                    begin
                        x_next       = x_reg + 8'd1;
                        data_next    = byte_value;
                        perm_rd_en   = 1'b1;
                        perm_rd_addr = x_reg + 8'd1;
                    end
                    else
                    begin
                        // The count saturates once the store is full.
                        if (count_reg < CW'(KEY_DEPTH))
                        begin
                            key_wr_en  = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        if (last_key)
                        begin
                            perm_clear = 1'b1;
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                        end
                    end
                end
            end
            ST_PG_RDY:
            begin
                a_next       = perm_rd_data;
                y_next       = y_reg + perm_rd_data;
                perm_rd_en   = 1'b1;
                perm_rd_addr = y_reg + perm_rd_data;
            end
            ST_PG_RDT:
            begin
                b_next       = perm_rd_data;
                t_next       = a_reg + perm_rd_data;
                perm_wr.en   = 1'b1;
                perm_wr.addr = x_reg;
                perm_wr.data = perm_rd_data;
                perm_rd_en   = 1'b1;
                perm_rd_addr = a_reg + perm_rd_data;
            end
            ST_PG_FIN:
            begin
                if (out_free)
                begin
                    perm_wr.en     = 1'b1;
                    perm_wr.addr   = y_reg;
                    perm_wr.data   = a_reg;
                    out_valid_next = 1'b1;
                    out_byte_next  = data_reg ^ ks ^ OUT_MASK;
                end
            end
            ST_KS_RDI:
            begin
                perm_rd_en   = 1'b1;
                perm_rd_addr = i_reg;
                key_rd_en    = 1'b1;
            end
            ST_KS_RDJ:
            begin
                a_next       = perm_rd_data;
                j_next       = j_reg + perm_rd_data + key_rd_data;
                perm_rd_en   = 1'b1;
                perm_rd_addr = j_reg + perm_rd_data + key_rd_data;
            end
            ST_KS_WRI:
            begin
                perm_wr.en   = 1'b1;
                perm_wr.addr = i_reg;
                perm_wr.data = perm_rd_data;
            end
            ST_KS_WRJ:
            begin
                perm_wr.en   = 1'b1;
                perm_wr.addr = j_reg;
                perm_wr.data = a_reg;
                i_next       = i_reg + 8'd1;
                // The key repeats cyclically over the bytes loaded.
                if (k_inc >= count_reg)
                begin
                    k_next = '0;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
                if (i_reg == LAST_STEP)
                begin
                    x_next     = '0;
                    y_next     = '0;
                    count_next = '0;
                end
            end
            default:
            begin
                perm_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            x_reg         <= '0;
            y_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        t_reg        <= t_next;
        data_reg     <= data_next;
        out_byte_reg <= out_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

endmodule

[hdl/rc4x_checker.sv]
// Port-level checks for the RC4 stream cipher, bound to the top level.
// Depends on rc4x_pkg and rc4_xor42_stream_cipher.
module rc4x_checker
    import rc4x_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              action,
    input logic              last_key,
    input logic              out_valid,
    input logic              out_stall,
    input logic [BYTE_W-1:0] out_byte
);

    // A data byte occupies the permutation memory for the following cycles.
    a_data_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && action == ACT_DATA) |=> in_stall ##1 in_stall ##1 in_stall)
        else $error("input taken while a data byte was still in progress");

    // A key byte that does not end the key leaves the input open in the next cycle.
    a_key_fast : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && action == ACT_KEY && !last_key) |=> !in_stall)
        else $error("plain key byte held off the next transfer");

    // The last key byte starts the schedule, which holds off new input.
    a_sched_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && action == ACT_KEY && last_key)
            |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
        else $error("input taken during the key schedule");

    // A stalled result stays in place.
    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_byte)))
        else $error("stalled result changed or vanished");

endmodule

bind rc4_xor42_stream_cipher rc4x_checker u_rc4x_checker (.*);

[dv/testbench.sv]
// Self-checking testbench for the RC4 stream cipher with the XOR-42 output mask.
// Depends on rc4x_pkg and rc4_xor42_stream_cipher; it predicts every output byte itself.
module testbench;
    import rc4x_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_DEPTH    = KEY_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 400;
    localparam int N_DIRECTED   = 18;

    // One row of the directed stimulus. Where the expected byte can be worked
    // out by hand, typed is set and exp holds it; otherwise the predictor decides.
    typedef struct packed {
        logic              act;
        logic [BYTE_W-1:0] val;
        logic              lst;
        logic              typed;
        logic [BYTE_W-1:0] exp;
    } stim_row_t;

    // The first two data bytes after reset see the identity permutation:
    // the keystream bytes are 2 and then 5, so 00 gives 28 and FF gives D0.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ACT_DATA, 8'h00, 1'b0, 1'b1, 8'h28},  // data before any key
        '{ACT_DATA, 8'hFF, 1'b0, 1'b1, 8'hD0},
        '{ACT_KEY,  8'h00, 1'b1, 1'b0, 8'h00},  // one-byte key of zero
        '{ACT_DATA, 8'h00, 1'b1, 1'b0, 8'h00},  // last_key is ignored on data
        '{ACT_DATA, 8'hFF, 1'b0, 1'b0, 8'h00},
        '{ACT_KEY,  8'hFF, 1'b1, 1'b0, 8'h00},  // one-byte key of all ones
        '{ACT_DATA, 8'h55, 1'b0, 1'b0, 8'h00},
        '{ACT_DATA, 8'hAA, 1'b0, 1'b0, 8'h00},
        '{ACT_KEY,  8'h01, 1'b0, 1'b0, 8'h00},  // three-byte key
        '{ACT_KEY,  8'h80, 1'b0, 1'b0, 8'h00},
        '{ACT_KEY,  8'h7F, 1'b1, 1'b0, 8'h00},
        '{ACT_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
        '{ACT_DATA, 8'hFF, 1'b0, 1'b0, 8'h00},
        '{ACT_DATA, 8'h3C, 1'b1, 1'b0, 8'h00},
        '{ACT_KEY,  8'hA5, 1'b0, 1'b0, 8'h00},  // fresh key after a schedule
        '{ACT_KEY,  8'h5A, 1'b1, 1'b0, 8'h00},
        '{ACT_DATA, 8'hC3, 1'b0, 1'b0, 8'h00},
        '{ACT_DATA, 8'hFF, 1'b0, 1'b0, 8'h00}
    };

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic              action     = ACT_KEY;
    logic [BYTE_W-1:0] byte_value = '0;
    logic              last_key   = 1'b0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [BYTE_W-1:0] out_byte;

    // While calm is set neither side idles, which gives one long stretch of
    // back-to-back transfers in the middle of the random part.
    bit calm = 1'b0;

    // Predictor state: the permutation, both indices and the key store.
    logic [BYTE_W-1:0] sbox [PERM_DEPTH];
    logic [BYTE_W-1:0] idx_x;
    logic [BYTE_W-1:0] idx_y;
    logic [BYTE_W-1:0] key_mem [KEY_DEPTH];
    int unsigned       key_cnt;

    // Output bytes still owed by the block, oldest first.
    logic [BYTE_W-1:0] owed_bytes [$];

    int n_sent       = 0;
    int n_key_bytes  = 0;
    int n_data_bytes = 0;
    int n_schedules  = 0;
    int n_saturated  = 0;
    int n_checked    = 0;
    int n_errors     = 0;

    rc4_xor42_stream_cipher #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .byte_value (byte_value),
        .last_key   (last_key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard limit on the run. A correct run needs well under a tenth of this.
    initial
    begin
        #5_000_000;
        $display("%0t: timeout, %0d output bytes still owed", $time, owed_bytes.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic void sbox_identity();
        int i;
        for (i = 0; i < PERM_DEPTH; i++)
            sbox[i] = BYTE_W'(i);
    endfunction

    // Key schedule: start from the identity and mix in the stored key bytes,
    // repeated cyclically. The key store is emptied afterwards.
    function automatic void mix_key();
        int unsigned       len;
        int unsigned       k;
        int                i;
        logic [BYTE_W-1:0] j;
        logic [BYTE_W-1:0] a;
        len = key_cnt;
        if (len == 0 || len > KEY_DEPTH)
            len = 1;
        sbox_identity();
        j = '0;
        k = 0;
        for (i = 0; i < PERM_DEPTH; i++)
        begin
            a = sbox[i];
            if (k >= len)
                k = 0;
            j = j + a + key_mem[k];
            sbox[i] = sbox[j];
            sbox[j] = a;
            k++;
        end
        idx_x   = '0;
        idx_y   = '0;
        key_cnt = 0;
        n_schedules++;
    endfunction

    // Advances the predictor by one accepted transfer. Returns 1 and the
    // ciphered byte for a data byte, 0 for a key byte.
    function automatic bit cipher_step(input logic act, input logic [BYTE_W-1:0] val,
                                       input logic lst, output logic [BYTE_W-1:0] res);
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] sum;
        res = '0;
        if (act == ACT_KEY)
        begin
            n_key_bytes++;
            // A full store drops the byte, but a last mark still starts the schedule.
            if (key_cnt < KEY_DEPTH)
            begin
                key_mem[key_cnt] = val;
                key_cnt++;
            end
            else
                n_saturated++;
            if (lst)
                mix_key();
            return 1'b0;
        end
        n_data_bytes++;
        idx_x = idx_x + 8'd1;
        a = sbox[idx_x];
        idx_y = idx_y + a;
        b = sbox[idx_y];
        sbox[idx_x] = b;
        sbox[idx_y] = a;
        sum = a + b;
        res = val ^ sbox[sum] ^ OUT_MASK;
        return 1'b1;
    endfunction

    // Presents one item on the input channel, idling first at random, and
    // holds it until the block takes it. The predictor runs in this same
    // process at the edge of the transfer, so nothing races with it.
    task automatic send_item(input logic act, input logic [BYTE_W-1:0] val, input logic lst,
                             input logic typed, input logic [BYTE_W-1:0] typed_exp);
        logic [BYTE_W-1:0] pred;
        bit                has_res;
        calm = (n_sent >= N_DIRECTED + 150) && (n_sent < N_DIRECTED + 230);
        while (!calm && $urandom_range(99) < 34)
        begin
            // The payload is free to wander while valid is low.
            in_valid   <= 1'b0;
            action     <= 1'($urandom);
            byte_value <= 8'($urandom);
            last_key   <= 1'($urandom);
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        byte_value <= val;
        last_key   <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        has_res = cipher_step(act, val, lst, pred);
        if (has_res)
            owed_bytes.push_back(typed ? typed_exp : pred);
        n_sent++;
    endtask

    // A well-formed key of the given length, the last byte marked.
    task automatic send_key(input int len);
        int i;
        for (i = 0; i < len; i++)
            send_item(ACT_KEY, 8'($urandom), (i == len - 1), 1'b0, '0);
    endtask

    // A run of data bytes; last_key is random since data ignores it.
    task automatic send_data(input int len);
        int i;
        for (i = 0; i < len; i++)
            send_item(ACT_DATA, 8'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    // Back-pressure on the output channel, driven at the rising edge.
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 34);
    end

    // Every output transfer is matched against the oldest owed byte.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_bytes.size() == 0)
            begin
                $display("%0t: unexpected output, expected none, got %02h", $time, out_byte);
                n_errors++;
            end
            else
            begin
                if (out_byte !== owed_bytes[0])
                begin
                    $display("%0t: out_byte mismatch, expected %02h, got %02h",
                             $time, owed_bytes[0], out_byte);
                    n_errors++;
                end
                void'(owed_bytes.pop_front());
                n_checked++;
            end
        end
    end

    initial
    begin
        int i;
        int pick;
        int len;

        sbox_identity();
        idx_x   = '0;
        idx_y   = '0;
        key_cnt = 0;
        for (i = 0; i < KEY_DEPTH; i++)
            key_mem[i] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extremes, keys of one and several bytes, and data
        // bytes both before any key and right after a schedule.
        for (i = 0; i < N_DIRECTED; i++)
            send_item(directed_rows[i].act, directed_rows[i].val, directed_rows[i].lst,
                      directed_rows[i].typed, directed_rows[i].exp);

        // Random part. Most of it is a fresh key followed by a run of data;
        // the rest is stray data and unterminated key fragments, which merge
        // into whatever key comes next.
        while (n_sent < N_DIRECTED + RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                case ($urandom_range(9))
                    0, 1:    len = KEY_DEPTH;                           // exactly fills the store
                    2, 3:    len = KEY_DEPTH + $urandom_range(1, 8);    // overflows the store
                    4:       len = 1;
                    default: len = $urandom_range(2, 12);
                endcase
                send_key(len);
                send_data($urandom_range(1, 24));
            end
            else if (pick < 90)
                send_data($urandom_range(1, 6));
            else
            begin
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++)
                    send_item(ACT_KEY, 8'($urandom), 1'b0, 1'b0, '0);
            end
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        // Drain every owed byte, then give a pending key schedule time to end
        // so that any stray output would still be seen.
        while (owed_bytes.size() != 0)
            @(posedge clk);
        repeat (1100) @(posedge clk);

        $display("Ran %0d key bytes (%0d dropped by a full store) and %0d data bytes",
                 n_key_bytes, n_saturated, n_data_bytes);
        $display("across %0d key schedules; %0d output bytes checked under random stalls.",
                 n_schedules, n_checked);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
hdl/rc4x_pkg.sv
hdl/rc4x_perm_ram.sv
hdl/rc4x_key_ram.sv
hdl/rc4_xor42_stream_cipher.sv
hdl/rc4x_checker.sv
dv/testbench.sv
